FILE: sv/rdtl_pkg.sv
// Shared types and constants of the range DFA transition lookup block.
// Used by the controller, the datapath and the top level; depends on nothing.
package rdtl_pkg;

    localparam int ACT_W   = 2;
    localparam int ENTRY_W = 12;
    localparam int STATE_W = 11;
    localparam int SYM_W   = 8;
    localparam int TGT_W   = 10;
    localparam int OFS_W   = 13;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE_RANGE  = 2'd0,
        ACT_WRITE_OFFSET = 2'd1,
        ACT_LOOKUP       = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFF_LO,
        ST_OFF_HI,
        ST_SETUP,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic ld_start;
        logic ld_range;
        logic setup;
        logic step;
        logic finish;
        logic sink_now;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_lookup;
        logic st_bad;
        logic empty;
        logic last;
    } t_dp_status;

endpackage

FILE: sv/rdtl_ctrl.sv
// Controller state machine of the range DFA transition lookup block.
// Depends on rdtl_pkg; drives the datapath through t_dp_cmd.
module rdtl_ctrl import rdtl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_busy = (r_state != ST_IDLE);
    assign take   = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take && i_status.is_lookup && !i_status.st_bad) begin
                    n_state = ST_OFF_LO;
                end
            end
            ST_OFF_LO: begin
                n_state = ST_OFF_HI;
            end
            ST_OFF_HI: begin
                n_state = i_status.empty ? ST_IDLE : ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (i_status.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.take = take;
        case (r_state)
            ST_IDLE: begin
                o_cmd.sink_now = take && i_status.is_lookup && i_status.st_bad;
            end
            ST_OFF_LO: begin
                o_cmd.ld_start = 1'b1;
            end
            ST_OFF_HI: begin
                o_cmd.ld_range = !i_status.empty;
                o_cmd.sink_now = i_status.empty;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            ST_SEARCH: begin
                o_cmd.step = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd.take = take;
            end
        endcase
    end

endmodule

FILE: sv/rdtl_datapath.sv
// Datapath of the range DFA transition lookup block: range entry and offset
// memories, binary search registers and the result register. Depends on rdtl_pkg.
module rdtl_datapath import rdtl_pkg::*; #(
    parameter int STATE_COUNT   = 1024,
    parameter int RANGE_ENTRIES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [ACT_W-1:0]   i_action,
    input  logic               i_table_select,
    input  logic [ENTRY_W-1:0] i_entry_index,
    input  logic [STATE_W-1:0] i_state_number,
    input  logic [SYM_W-1:0]   i_range_low,
    input  logic [SYM_W-1:0]   i_range_high,
    input  logic [TGT_W-1:0]   i_target_state,
    input  logic [OFS_W-1:0]   i_offset_value,
    input  logic [SYM_W-1:0]   i_symbol,
    output logic               o_result_valid,
    output logic [TGT_W-1:0]   o_next_state,
    output logic               o_is_sink
);

    localparam int EW     = $clog2(RANGE_ENTRIES);
    localparam int CW     = EW + 1;
    localparam int EDEPTH = 2 * RANGE_ENTRIES;
    localparam int RAW    = $clog2(EDEPTH);
    localparam int ODEPTH = 2 * (STATE_COUNT + 1);
    localparam int OAW    = $clog2(ODEPTH);
    localparam int EMW    = 2 * SYM_W + TGT_W;

    logic [EMW-1:0]   r_entry_mem [EDEPTH];
    logic [OFS_W-1:0] r_offset_mem [ODEPTH];
    logic [EMW-1:0]   r_rd_entry;
    logic [OFS_W-1:0] r_rd_off;

    logic             r_tbl;
    logic [SYM_W-1:0] r_sym;
    logic [OAW-1:0]   r_oaddr;
    logic [CW-1:0]    r_start;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_first;
    logic [CW-1:0]    r_count;
    logic [RAW-1:0]   r_base;
    logic [SYM_W-1:0] r_left_high;
    logic [TGT_W-1:0] r_left_tgt;
    logic [SYM_W-1:0] r_right_low;
    logic [TGT_W-1:0] r_right_tgt;

    logic             r_res_valid;
    logic [TGT_W-1:0] r_next_state;
    logic             r_is_sink;
    logic             n_res_valid;
    logic [TGT_W-1:0] n_next_state;
    logic             n_is_sink;

    logic             entry_we;
    logic [RAW-1:0]   entry_waddr;
    logic [RAW-1:0]   entry_raddr;
    logic             off_we;
    logic [OAW-1:0]   off_addr_in;
    logic [OAW-1:0]   off_raddr;

    logic [SYM_W-1:0] rd_low;
    logic [SYM_W-1:0] rd_high;
    logic [TGT_W-1:0] rd_tgt;
    logic [CW-1:0]    start_c;
    logic [CW-1:0]    stop_c;
    logic [CW-1:0]    half;
    logic [CW-1:0]    mid;
    logic [CW-1:0]    first_l;
    logic [CW-1:0]    count_l;
    logic [RAW-1:0]   addr_mid;
    logic [RAW-1:0]   addr_l;
    logic [RAW-1:0]   addr_g;
    logic             is_lt;

    // Offsets beyond the range store are limited to its size when used.
    function automatic logic [CW-1:0] clamp_ofs(input logic [OFS_W-1:0] v);
        if (32'(v) > 32'(RANGE_ENTRIES)) begin
            return CW'(RANGE_ENTRIES);
        end
        return CW'(v);
    endfunction

    assign rd_low  = r_rd_entry[EMW-1 -: SYM_W];
    assign rd_high = r_rd_entry[TGT_W+SYM_W-1 -: SYM_W];
    assign rd_tgt  = r_rd_entry[TGT_W-1:0];

    assign start_c = clamp_ofs(r_rd_off);
    assign stop_c  = clamp_ofs(r_rd_off);

    assign entry_we    = i_cmd.take && (i_action == ACT_WRITE_RANGE)
                         && (32'(i_entry_index) < 32'(RANGE_ENTRIES));
    assign entry_waddr = i_table_select ? RAW'(RANGE_ENTRIES) + RAW'(i_entry_index)
                                        : RAW'(i_entry_index);
    assign off_we      = i_cmd.take && (i_action == ACT_WRITE_OFFSET)
                         && (32'(i_state_number) <= 32'(STATE_COUNT));
    assign off_addr_in = i_table_select ? OAW'(STATE_COUNT + 1) + OAW'(i_state_number)
                                        : OAW'(i_state_number);
    assign off_raddr   = i_cmd.take ? off_addr_in : r_oaddr + OAW'(1);

    // Both outcomes of the current probe are prepared from registers, so the
    // compare only selects the next probe address.
    assign half     = r_count >> 1;
    assign mid      = r_first + half;
    assign first_l  = mid + CW'(1);
    assign count_l  = r_count - half - CW'(1);
    assign addr_mid = r_base + RAW'(mid);
    assign addr_l   = r_base + RAW'(first_l) + RAW'(count_l >> 1);
    assign addr_g   = r_base + RAW'(r_first) + RAW'(half >> 1);
    assign is_lt    = rd_low < r_sym;

    assign entry_raddr = i_cmd.setup ? addr_mid : (is_lt ? addr_l : addr_g);

    assign o_status.is_lookup = (i_action == ACT_LOOKUP);
    assign o_status.st_bad    = (32'(i_state_number) >= 32'(STATE_COUNT));
    assign o_status.empty     = (stop_c <= r_start);
    assign o_status.last      = is_lt ? (count_l == '0) : (half == '0);

    always_ff @(posedge i_clk) begin
        if (entry_we) begin
            r_entry_mem[entry_waddr] <= {i_range_low, i_range_high, i_target_state};
        end
        r_rd_entry <= r_entry_mem[entry_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            r_offset_mem[off_addr_in] <= i_offset_value;
        end
        r_rd_off <= r_offset_mem[off_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_tbl   <= i_table_select;
            r_sym   <= i_symbol;
            r_oaddr <= off_addr_in;
        end
        if (i_cmd.ld_start) begin
            r_start <= start_c;
        end
        if (i_cmd.ld_range) begin
            r_n     <= stop_c - r_start;
            r_count <= stop_c - r_start;
            r_first <= '0;
            r_base  <= r_tbl ? RAW'(RANGE_ENTRIES) + RAW'(r_start) : RAW'(r_start);
        end
        // The last probe below the symbol sits just left of first, the last
        // probe at or above it sits at first once the search has closed.
        if (i_cmd.step) begin
            if (is_lt) begin
                r_first     <= first_l;
                r_count     <= count_l;
                r_left_high <= rd_high;
                r_left_tgt  <= rd_tgt;
            end else begin
                r_count     <= half;
                r_right_low <= rd_low;
                r_right_tgt <= rd_tgt;
            end
        end
    end

    always_comb begin
        n_res_valid  = 1'b0;
        n_next_state = '0;
        n_is_sink    = 1'b1;
        if (i_cmd.sink_now) begin
            n_res_valid = 1'b1;
        end else if (i_cmd.finish) begin
            n_res_valid = 1'b1;
            if ((r_first < r_n) && (r_right_low == r_sym)) begin
                n_next_state = r_right_tgt;
                n_is_sink    = 1'b0;
            end else if ((r_first != '0) && (r_sym <= r_left_high)) begin
                n_next_state = r_left_tgt;
                n_is_sink    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
        r_next_state <= n_next_state;
        r_is_sink    <= n_is_sink;
    end

    assign o_result_valid = r_res_valid;
    assign o_next_state   = r_next_state;
    assign o_is_sink      = r_is_sink;

endmodule

FILE: sv/range_dfa_transition_lookup_top.sv
// Top level of the range DFA transition lookup block.
// Depends on rdtl_pkg, rdtl_ctrl and rdtl_datapath.
//
// Range entry and offset writes are taken and give no result;
// busy stays low. A lookup of a state at or beyond STATE_COUNT answers sink
// in the cycle after it is taken, without raising busy. Any other lookup
// holds busy through the states OFF_LO, OFF_HI, SETUP, SEARCH and FINISH, or
// through OFF_LO and OFF_HI alone when the state has no ranges; in SEARCH the
// binary search makes one probe per cycle into the range entry memory. The
// result is on o_next_state and o_is_sink for the one cycle in which
// o_result_valid is high, which is the first cycle in which busy is low
// again. The receiver cannot stall the block and must take it then.
module range_dfa_transition_lookup_top import rdtl_pkg::*; #(
    parameter int STATE_COUNT   = 1024,
    parameter int RANGE_ENTRIES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ACT_W-1:0]   i_action,
    input  logic               i_table_select,
    input  logic [ENTRY_W-1:0] i_entry_index,
    input  logic [STATE_W-1:0] i_state_number,
    input  logic [SYM_W-1:0]   i_range_low,
    input  logic [SYM_W-1:0]   i_range_high,
    input  logic [TGT_W-1:0]   i_target_state,
    input  logic [OFS_W-1:0]   i_offset_value,
    input  logic [SYM_W-1:0]   i_symbol,
    output logic               o_result_valid,
    output logic [TGT_W-1:0]   o_next_state,
    output logic               o_is_sink
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rdtl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    rdtl_datapath #(
        .STATE_COUNT   (STATE_COUNT),
        .RANGE_ENTRIES (RANGE_ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_action       (i_action),
        .i_table_select (i_table_select),
        .i_entry_index  (i_entry_index),
        .i_state_number (i_state_number),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_target_state (i_target_state),
        .i_offset_value (i_offset_value),
        .i_symbol       (i_symbol),
        .o_result_valid (o_result_valid),
        .o_next_state   (o_next_state),
        .o_is_sink      (o_is_sink)
    );

endmodule

FILE: sv/rdtl_checker.sv
// Port-level checks for the range DFA transition lookup block, bound to the top.
// Depends on rdtl_pkg and range_dfa_transition_lookup_top.
module rdtl_checker import rdtl_pkg::*; #(
    parameter int STATE_COUNT = 1024
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [ACT_W-1:0]   i_action,
    input logic [STATE_W-1:0] i_state_number,
    input logic               o_result_valid,
    input logic [TGT_W-1:0]   o_next_state,
    input logic               o_is_sink
);

    logic take;
    logic lookup;
    logic st_bad;

    assign take   = start && !busy;
    assign lookup = (i_action == ACT_LOOKUP);
    assign st_bad = (32'(i_state_number) >= 32'(STATE_COUNT));

    // A sink result always carries a zero next state.
    a_sink_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_is_sink |-> o_next_state == '0)
        else $error("sink result with nonzero next state");

    // A lookup of a state outside the table answers sink in the next cycle.
    a_bad_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && lookup && st_bad |=> o_result_valid && o_is_sink && !busy)
        else $error("out of range state did not answer sink at once");

    // Write items and ignored items leave the block free and give no result.
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !lookup |=> !busy && !o_result_valid)
        else $error("write item made the block busy or gave a result");

    // A lookup of a valid state starts the search.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && lookup && !st_bad |=> busy && !o_result_valid)
        else $error("lookup did not start the search");

    // Every search ends with its result in the cycle busy falls.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_result_valid)
        else $error("search ended without a result");

endmodule

bind range_dfa_transition_lookup_top rdtl_checker #(
    .STATE_COUNT (STATE_COUNT)
) u_checker (.*);

FILE: tb/tb_range_dfa_transition_lookup_top.sv
// Self-checking testbench for range_dfa_transition_lookup_top. Builds range tables
// through the command port and checks every lookup against an in-bench predictor
// or a hand-written answer. Depends on rdtl_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_range_dfa_transition_lookup_top;
    import rdtl_pkg::*;

    localparam int STATE_COUNT   = 1024;
    localparam int RANGE_ENTRIES = 4096;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 600;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]   act;
        logic               tbl;
        logic [ENTRY_W-1:0] entry;
        logic [STATE_W-1:0] state;
        logic [SYM_W-1:0]   lo;
        logic [SYM_W-1:0]   hi;
        logic [TGT_W-1:0]   tgt;
        logic [OFS_W-1:0]   ofs;
        logic [SYM_W-1:0]   sym;
    } cmd_t;

    typedef struct packed {
        logic [TGT_W-1:0] nxt_state;
        logic             sink;
    } result_t;

    typedef struct packed {
        cmd_t    c;
        logic    chk;
        result_t want;
    } script_row_t;

    // Rows with chk set carry a hand-written answer; the rest go to the predictor.
    localparam script_row_t SCRIPT [DIRECTED_ROWS] = '{
        '{'{ACT_LOOKUP, 1'b0, 12'd0, 11'd1024, 8'd0, 8'd0, 10'd0, 13'd0, 8'd0},
          1'b1, '{10'd0, 1'b1}},
        '{'{ACT_LOOKUP, 1'b1, 12'd4095, 11'd2047, 8'd255, 8'd255, 10'd1023, 13'd8191, 8'd255},
          1'b1, '{10'd0, 1'b1}},
        '{'{ACT_RESERVED, 1'b1, 12'd4095, 11'd2047, 8'd255, 8'd255, 10'd1023, 13'd8191, 8'd255},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_OFFSET, 1'b0, 12'd0, 11'd2047, 8'd0, 8'd0, 10'd0, 13'd8191, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_RANGE, 1'b0, 12'd0, 11'd0, 8'd0, 8'd9, 10'd1023, 13'd0, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_RANGE, 1'b0, 12'd1, 11'd0, 8'd10, 8'd10, 10'd5, 13'd0, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_RANGE, 1'b0, 12'd2, 11'd0, 8'd200, 8'd255, 10'd7, 13'd0, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_OFFSET, 1'b0, 12'd0, 11'd0, 8'd0, 8'd0, 10'd0, 13'd0, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_OFFSET, 1'b0, 12'd0, 11'd1, 8'd0, 8'd0, 10'd0, 13'd3, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_LOOKUP, 1'b0, 12'd0, 11'd0, 8'd0, 8'd0, 10'd0, 13'd0, 8'd0},
          1'b1, '{10'd1023, 1'b0}},
        '{'{ACT_LOOKUP, 1'b0, 12'd0, 11'd0, 8'd0, 8'd0, 10'd0, 13'd0, 8'd10},
          1'b1, '{10'd5, 1'b0}},
        '{'{ACT_LOOKUP, 1'b0, 12'd0, 11'd0, 8'd0, 8'd0, 10'd0, 13'd0, 8'd11},
          1'b1, '{10'd0, 1'b1}},
        '{'{ACT_LOOKUP, 1'b0, 12'd0, 11'd0, 8'd0, 8'd0, 10'd0, 13'd0, 8'd255},
          1'b1, '{10'd7, 1'b0}},
        '{'{ACT_LOOKUP, 1'b0, 12'd0, 11'd0, 8'd0, 8'd0, 10'd0, 13'd0, 8'd150},
          1'b1, '{10'd0, 1'b1}},
        '{'{ACT_WRITE_OFFSET, 1'b1, 12'd0, 11'd5, 8'd0, 8'd0, 10'd0, 13'd10, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_OFFSET, 1'b1, 12'd0, 11'd6, 8'd0, 8'd0, 10'd0, 13'd3, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_LOOKUP, 1'b1, 12'd0, 11'd5, 8'd0, 8'd0, 10'd0, 13'd0, 8'd42},
          1'b1, '{10'd0, 1'b1}},
        '{'{ACT_WRITE_OFFSET, 1'b1, 12'd0, 11'd7, 8'd0, 8'd0, 10'd0, 13'd3, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_LOOKUP, 1'b1, 12'd0, 11'd6, 8'd0, 8'd0, 10'd0, 13'd0, 8'd0},
          1'b1, '{10'd0, 1'b1}},
        '{'{ACT_WRITE_RANGE, 1'b1, 12'd4095, 11'd0, 8'd128, 8'd0, 10'd682, 13'd0, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_OFFSET, 1'b1, 12'd0, 11'd1023, 8'd0, 8'd0, 10'd0, 13'd4095, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_WRITE_OFFSET, 1'b1, 12'd0, 11'd1024, 8'd0, 8'd0, 10'd0, 13'd8191, 8'd0},
          1'b0, '{10'd0, 1'b0}},
        '{'{ACT_LOOKUP, 1'b1, 12'd0, 11'd1023, 8'd0, 8'd0, 10'd0, 13'd0, 8'd128},
          1'b1, '{10'd682, 1'b0}},
        '{'{ACT_LOOKUP, 1'b1, 12'd0, 11'd1023, 8'd0, 8'd0, 10'd0, 13'd0, 8'd129},
          1'b1, '{10'd0, 1'b1}},
        '{'{ACT_LOOKUP, 1'b1, 12'd0, 11'd1023, 8'd0, 8'd0, 10'd0, 13'd0, 8'd127},
          1'b1, '{10'd0, 1'b1}}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [ACT_W-1:0]   i_action;
    logic               i_table_select;
    logic [ENTRY_W-1:0] i_entry_index;
    logic [STATE_W-1:0] i_state_number;
    logic [SYM_W-1:0]   i_range_low;
    logic [SYM_W-1:0]   i_range_high;
    logic [TGT_W-1:0]   i_target_state;
    logic [OFS_W-1:0]   i_offset_value;
    logic [SYM_W-1:0]   i_symbol;
    logic               o_result_valid;
    logic [TGT_W-1:0]   o_next_state;
    logic               o_is_sink;

    // Mirror of both transition tables.
    bit [SYM_W-1:0] low_mem      [2][RANGE_ENTRIES];
    bit [SYM_W-1:0] high_mem     [2][RANGE_ENTRIES];
    bit [TGT_W-1:0] tgt_mem      [2][RANGE_ENTRIES];
    bit             entry_loaded [2][RANGE_ENTRIES];
    bit [OFS_W-1:0] ofs_mem      [2][STATE_COUNT+1];
    bit             ofs_loaded   [2][STATE_COUNT+1];

    result_t          pending_results[$];
    result_t          oldest;
    logic [STATE_W:0] built_states[$];

    int idle_mode;
    int useful_items;
    int items_accepted;
    int mismatch_count;
    int hit_answers;
    int sink_answers;
    int cycle_count;

    range_dfa_transition_lookup_top #(
        .STATE_COUNT  (STATE_COUNT),
        .RANGE_ENTRIES(RANGE_ENTRIES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_table_select(i_table_select),
        .i_entry_index (i_entry_index),
        .i_state_number(i_state_number),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_target_state(i_target_state),
        .i_offset_value(i_offset_value),
        .i_symbol      (i_symbol),
        .o_result_valid(o_result_valid),
        .o_next_state  (o_next_state),
        .o_is_sink     (o_is_sink)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned bounded_offset(input bit [OFS_W-1:0] v);
        return (v > RANGE_ENTRIES) ? RANGE_ENTRIES : int'(v);
    endfunction

    // Lower-bound search over the ranges of one state, then the hit test.
    function automatic result_t predict_transition(input bit t, input int unsigned s,
                                                   input logic [SYM_W-1:0] sym);
        result_t     r;
        int unsigned a, b, n, first, count, half;
        r.nxt_state = '0;
        r.sink      = 1'b1;
        if (s >= STATE_COUNT) return r;
        a = bounded_offset(ofs_mem[t][s]);
        b = bounded_offset(ofs_mem[t][s+1]);
        if (b <= a) return r;
        n     = b - a;
        first = 0;
        count = n;
        while (count > 0) begin
            half = count / 2;
            if (low_mem[t][a + first + half] < sym) begin
                first = first + half + 1;
                count = count - half - 1;
            end else begin
                count = half;
            end
        end
        if (first < n && low_mem[t][a + first] == sym) begin
            r.nxt_state = tgt_mem[t][a + first];
            r.sink      = 1'b0;
        end else if (first > 0 && sym <= high_mem[t][a + first - 1]) begin
            r.nxt_state = tgt_mem[t][a + first - 1];
            r.sink      = 1'b0;
        end
        return r;
    endfunction

    function automatic void update_tables(input cmd_t c, output bit has_res,
                                          output result_t res);
        has_res = 1'b0;
        res     = '0;
        case (c.act)
            ACT_WRITE_RANGE: begin
                low_mem[c.tbl][c.entry]      = c.lo;
                high_mem[c.tbl][c.entry]     = c.hi;
                tgt_mem[c.tbl][c.entry]      = c.tgt;
                entry_loaded[c.tbl][c.entry] = 1'b1;
                useful_items++;
            end
            ACT_WRITE_OFFSET: begin
                if (c.state <= STATE_COUNT) begin
                    ofs_mem[c.tbl][c.state]    = c.ofs;
                    ofs_loaded[c.tbl][c.state] = 1'b1;
                    useful_items++;
                end
            end
            ACT_LOOKUP: begin
                res     = predict_transition(c.tbl, c.state, c.sym);
                has_res = 1'b1;
                useful_items++;
            end
            default: ;
        endcase
    endfunction

    // A lookup may only touch offsets and range entries that were loaded.
    function automatic bit readable(input bit t, input int unsigned s);
        int unsigned a, b;
        if (s >= STATE_COUNT) return 1'b1;
        if (!ofs_loaded[t][s] || !ofs_loaded[t][s+1]) return 1'b0;
        a = bounded_offset(ofs_mem[t][s]);
        b = bounded_offset(ofs_mem[t][s+1]);
        for (int unsigned i = a; i < b; i++) begin
            if (!entry_loaded[t][i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol(input bit t, input int unsigned s);
        int unsigned a, b, j;
        a = bounded_offset(ofs_mem[t][s]);
        b = bounded_offset(ofs_mem[t][s+1]);
        if (b <= a || $urandom_range(0, 4) == 0) return SYM_W'($urandom_range(0, 255));
        j = $urandom_range(a, b - 1);
        case ($urandom_range(0, 3))
            0:       return low_mem[t][j];
            1:       return high_mem[t][j];
            2:       return low_mem[t][j] - 8'd1;
            default: return high_mem[t][j] + 8'd1;
        endcase
    endfunction

    function automatic cmd_t random_cmd(input logic [ACT_W-1:0] act);
        cmd_t c;
        c.act   = act;
        c.tbl   = 1'($urandom_range(0, 1));
        c.entry = ENTRY_W'($urandom_range(0, 4095));
        c.state = STATE_W'($urandom_range(0, 2047));
        c.lo    = SYM_W'($urandom_range(0, 255));
        c.hi    = SYM_W'($urandom_range(0, 255));
        c.tgt   = TGT_W'($urandom_range(0, 1023));
        c.ofs   = OFS_W'($urandom_range(0, 8191));
        c.sym   = SYM_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic int next_gap();
        case (idle_mode)
            0:       return 0;
            1:       return int'($urandom_range(0, 16));
            default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
        endcase
    endfunction

    // Present one item and hold it until the block takes it. Start is left high so
    // that a following item with no gap goes out back to back.
    task automatic issue(input cmd_t c, input bit typed, input result_t typed_res);
        int      gap;
        bit      has_res;
        result_t res;
        gap = next_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= c.act;
        i_table_select <= c.tbl;
        i_entry_index  <= c.entry;
        i_state_number <= c.state;
        i_range_low    <= c.lo;
        i_range_high   <= c.hi;
        i_target_state <= c.tgt;
        i_offset_value <= c.ofs;
        i_symbol       <= c.sym;
        do @(posedge i_clk); while (busy);
        items_accepted++;
        update_tables(c, has_res, res);
        if (has_res) pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_offsets(input bit t, input int unsigned s,
                                 input int unsigned first_ofs, input int unsigned stop_ofs);
        cmd_t c;
        c       = random_cmd(ACT_WRITE_OFFSET);
        c.tbl   = t;
        c.state = STATE_W'(s);
        c.ofs   = OFS_W'(first_ofs);
        issue(c, 1'b0, '0);
        c       = random_cmd(ACT_WRITE_OFFSET);
        c.tbl   = t;
        c.state = STATE_W'(s + 1);
        c.ofs   = OFS_W'(stop_ofs);
        issue(c, 1'b0, '0);
    endtask

    task automatic probe_state(input bit t, input int unsigned s, input int unsigned k);
        cmd_t c;
        for (int unsigned i = 0; i < k; i++) begin
            if (!readable(t, s)) return;
            c       = random_cmd(ACT_LOOKUP);
            c.tbl   = t;
            c.state = STATE_W'(s);
            c.sym   = pick_symbol(t, s);
            issue(c, 1'b0, '0);
        end
    endtask

    // Load n range entries at base for state s, then probe the state. Ordered
    // segments are sorted and disjoint; the others carry arbitrary bounds.
    task automatic build_state(input bit t, input int unsigned s, input int unsigned base,
                               input int unsigned n, input bit ordered,
                               input int unsigned stop_ofs);
        cmd_t        c;
        int unsigned cursor, half, lo, hi;
        bit          offsets_first;
        half          = (n > 0) ? (256 / n) / 2 : 0;
        cursor        = 0;
        offsets_first = 1'($urandom_range(0, 1));
        if (offsets_first) write_offsets(t, s, base, stop_ofs);
        for (int unsigned j = 0; j < n; j++) begin
            if (ordered) begin
                lo     = cursor + $urandom_range(0, half);
                hi     = lo + ((half > 0) ? $urandom_range(0, half - 1) : 0);
                cursor = hi + 1;
            end else begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(0, 255);
            end
            c       = random_cmd(ACT_WRITE_RANGE);
            c.tbl   = t;
            c.entry = ENTRY_W'(base + j);
            c.lo    = SYM_W'(lo);
            c.hi    = SYM_W'(hi);
            issue(c, 1'b0, '0);
        end
        if (!offsets_first) write_offsets(t, s, base, stop_ofs);
        built_states.push_back({t, STATE_W'(s)});
        if (built_states.size() > 64) void'(built_states.pop_front());
        probe_state(t, s, $urandom_range(2, 6));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (o_is_sink) sink_answers++;
            else hit_answers++;
            if (pending_results.size() == 0) begin
                $error("result with no lookup outstanding: next_state %0d, is_sink %0d",
                       o_next_state, o_is_sink);
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_next_state !== oldest.nxt_state) begin
                    $error("next_state mismatch: expected %0d, actual %0d",
                           oldest.nxt_state, o_next_state);
                    mismatch_count++;
                end
                if (o_is_sink !== oldest.sink) begin
                    $error("is_sink mismatch: expected %0d, actual %0d",
                           oldest.sink, o_is_sink);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        cmd_t        c;
        int unsigned pick, base, t, s, m, hi_ofs;
        bit          big_done;
        logic [STATE_W:0] e;
        idle_mode      = 1;
        big_done       = 1'b0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_action       <= '0;
        i_table_select <= 1'b0;
        i_entry_index  <= '0;
        i_state_number <= '0;
        i_range_low    <= '0;
        i_range_high   <= '0;
        i_target_state <= '0;
        i_offset_value <= '0;
        i_symbol       <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (SCRIPT[i]) issue(SCRIPT[i].c, SCRIPT[i].chk, SCRIPT[i].want);
        drain();

        while (useful_items < DIRECTED_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) idle_mode = $urandom_range(0, 2);
            t = $urandom_range(0, 1);
            s = $urandom_range(0, STATE_COUNT - 1);
            // One deep state: every symbol in a range of its own.
            if (!big_done && useful_items > 250) begin
                base = $urandom_range(0, RANGE_ENTRIES - 256);
                build_state(t, s, base, 256, 1'b1, base + 256);
                big_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m    = $urandom_range(0, 12);
                base = $urandom_range(0, RANGE_ENTRIES - m);
                build_state(t, s, base, m, 1'b1, base + m);
            end else if (pick < 70) begin
                m    = $urandom_range(1, 10);
                base = $urandom_range(0, RANGE_ENTRIES - m);
                build_state(t, s, base, m, 1'b0, base + m);
            end else if (pick < 85) begin
                if (built_states.size() != 0) begin
                    e = built_states[$urandom_range(0, built_states.size() - 1)];
                    probe_state(e[STATE_W], e[STATE_W-1:0], $urandom_range(1, 4));
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: issue(random_cmd(ACT_RESERVED), 1'b0, '0);
                    1: begin
                        c       = random_cmd(ACT_LOOKUP);
                        c.state = STATE_W'($urandom_range(STATE_COUNT, 2047));
                        issue(c, 1'b0, '0);
                    end
                    2: begin
                        c       = random_cmd(ACT_WRITE_OFFSET);
                        c.state = STATE_W'($urandom_range(STATE_COUNT + 1, 2047));
                        issue(c, 1'b0, '0);
                    end
                    3: begin
                        // Ranges at the top of the store, end offset at or past the store size.
                        m = $urandom_range(1, 8);
                        build_state(t, s, RANGE_ENTRIES - m, m, 1'($urandom_range(0, 1)),
                                    $urandom_range(RANGE_ENTRIES, 8191));
                    end
                    default: begin
                        hi_ofs = $urandom_range(1, 8191);
                        write_offsets(t, s, hi_ofs, $urandom_range(0, hi_ofs - 1));
                        probe_state(t, s, 2);
                    end
                endcase
            end
            if ($urandom_range(0, 39) == 0) drain();
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d items through both tables, deep and clamped states included.",
                 items_accepted);
        $display("Checked %0d transition lookups: %0d hits, %0d sink answers.",
                 hit_answers + sink_answers, hit_answers, sink_answers);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
